@@ design/png_scanline_unfilter_macros.svh @@
// Assertion macros for the PNG scanline unfilter checker.
// No dependencies; included by the checker file only.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psu assertion failed");

`endif

@@ design/psu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter.
// No dependencies; used by every other file of the block except the assertion macros header.
`default_nettype none

package psu_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int COL_W           = $clog2(MAX_ROW_BYTES);
    localparam int BPP_IDX_W       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int BPP_W           = 4;
    localparam int ROW_W           = 14;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES    = CFG_IDX_W'(1);

    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(4);
    localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(1024);

    typedef enum logic [2:0] {
        FILT_NONE    = 3'd0,
        FILT_SUB     = 3'd1,
        FILT_UP      = 3'd2,
        FILT_AVG     = 3'd3,
        FILT_PAETH   = 3'd4,
        FILT_UNKNOWN = 3'd5
    } filter_t;

    // Effective configuration after clamping
    typedef struct packed {
        logic [BPP_IDX_W-1:0] bpp_idx;   // pixel stride - 1
        logic [ROW_W-1:0]     row_len;   // 1..MAX_ROW_BYTES
    } cfg_view_t;

    // One classified data word from front to back
    typedef struct packed {
        logic [7:0]       raw_byte;
        logic [COL_W-1:0] col;
        filter_t          filt;
        logic             first_row;
        logic             left_edge;
        logic             last;
    } qitem_t;

endpackage

`default_nettype wire

@@ design/psu_stream_if.sv @@
// Input stream channel: one inflated byte per word.
// Depends on psu_pkg.
`default_nettype none

interface psu_stream_if import psu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       start_of_image;

    modport source (output valid, output raw_byte, output start_of_image, input ready);
    modport sink   (input valid, input raw_byte, input start_of_image, output ready);
endinterface

`default_nettype wire

@@ design/psu_pixel_if.sv @@
// Output channel: one reconstructed byte per word.
// Depends on psu_pkg.
`default_nettype none

interface psu_pixel_if import psu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_in_row;
    logic       bad_filter;

    modport source (output valid, output out_byte, output last_in_row, output bad_filter,
                    input ready);
    modport sink   (input valid, input out_byte, input last_in_row, input bad_filter,
                    output ready);
endinterface

`default_nettype wire

@@ design/psu_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on psu_pkg.
`default_nettype none

interface psu_cfg_if import psu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/psu_front.sv @@
// Front end: parses filter bytes, tracks row position, classifies data words.
// Depends on psu_pkg and psu_stream_if.
`default_nettype none

module psu_front import psu_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psu_stream_if.sink    stream,
    input  wire cfg_view_t cfg_view,
    input  wire logic     full,
    output logic          push,
    output qitem_t        push_item
);

    logic             expect_reg, expect_next;
    logic             first_row_reg, first_row_next;
    filter_t          filt_reg, filt_next;
    logic [ROW_W-1:0] column_reg, column_next;

    logic             accept;
    logic             is_filter;
    logic             last;
    logic [ROW_W:0]   column_inc;
    filter_t          new_filt;

    assign stream.ready = !full;

    always_comb
    begin
        accept     = stream.valid && stream.ready;
        is_filter  = stream.start_of_image || expect_reg;
        column_inc = {1'b0, column_reg} + (ROW_W+1)'(1);
        last       = column_inc >= {1'b0, cfg_view.row_len};
        new_filt   = (stream.raw_byte > 8'(FILT_PAETH)) ? FILT_UNKNOWN :
                     filter_t'(stream.raw_byte[2:0]);

        push_item.raw_byte  = stream.raw_byte;
        push_item.col       = (column_reg >= ROW_W'(MAX_ROW_BYTES)) ?
                              COL_W'(MAX_ROW_BYTES - 1) : column_reg[COL_W-1:0];
        push_item.filt      = filt_reg;
        push_item.first_row = first_row_reg;
        push_item.left_edge = column_reg <= ROW_W'(cfg_view.bpp_idx);
        push_item.last      = last;

        push           = accept && !is_filter;
        expect_next    = expect_reg;
        first_row_next = first_row_reg;
        filt_next      = filt_reg;
        column_next    = column_reg;

        if (accept)
        begin
            if (is_filter)
            begin
                filt_next   = new_filt;
                expect_next = 1'b0;
                column_next = '0;
                if (stream.start_of_image)
                begin
                    first_row_next = 1'b1;
                end
            end
            else if (last)
            begin
                column_next    = '0;
                expect_next    = 1'b1;
                first_row_next = 1'b0;
            end
            else
            begin
                column_next = column_inc[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg    <= 1'b1;
            first_row_reg <= 1'b1;
            filt_reg      <= FILT_NONE;
            column_reg    <= '0;
        end
        else
        begin
            expect_reg    <= expect_next;
            first_row_reg <= first_row_next;
            filt_reg      <= filt_next;
            column_reg    <= column_next;
        end
    end

endmodule

`default_nettype wire

@@ design/psu_queue.sv @@
// Short FIFO of classified data words between front and back.
// Depends on psu_pkg.
`default_nettype none

module psu_queue import psu_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire qitem_t push_item,
    input  wire logic   pop,
    output qitem_t      head,
    output logic        head_valid,
    output logic        full
);

    qitem_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        head       = slot_reg[rd_ptr_reg];
        head_valid = count_reg != '0;
        full       = count_reg == QCNT_W'(QUEUE_DEPTH);

        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/psu_back.sv @@
// Back end: line buffer, left/above-left history, filter arithmetic, output register.
// Depends on psu_pkg and psu_pixel_if.
`default_nettype none

module psu_back import psu_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [BPP_IDX_W-1:0] bpp_idx,
    input  wire qitem_t               head,
    input  wire logic                 head_valid,
    output logic                      pop,
    psu_pixel_if.source               pixels
);

    // Prior row line buffer
    logic [7:0] line_mem [MAX_ROW_BYTES];
    logic [7:0] above_rd_reg;

    qitem_t     e_item_reg;
    logic       e_valid_reg, e_valid_next;
    logic       byp_hit_reg;
    logic [7:0] byp_data_reg;

    logic [7:0] left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0] up_hist_reg   [MAX_PIXEL_BYTES];

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_bad_reg;

    logic        e_adv;
    logic [7:0]  a, b, c, pred, result;
    logic [8:0]  ab_sum;
    logic signed [10:0] pa, pb, pc;

    assign pixels.valid       = out_valid_reg;
    assign pixels.out_byte    = out_byte_reg;
    assign pixels.last_in_row = out_last_reg;
    assign pixels.bad_filter  = out_bad_reg;

    always_comb
    begin
        e_adv = e_valid_reg && (!out_valid_reg || pixels.ready);
        pop   = head_valid && (!e_valid_reg || e_adv);

        a = e_item_reg.left_edge ? 8'd0 : left_hist_reg[bpp_idx];
        c = e_item_reg.left_edge ? 8'd0 : up_hist_reg[bpp_idx];
        if (e_item_reg.first_row)
        begin
            b = 8'd0;
        end
        else
        begin
            b = byp_hit_reg ? byp_data_reg : above_rd_reg;
        end

        ab_sum = {1'b0, a} + {1'b0, b};

        // Paeth distances: |b-c|, |a-c|, |a+b-2c|
        pa = 11'(signed'({3'b000, b})) - 11'(signed'({3'b000, c}));
        pb = 11'(signed'({3'b000, a})) - 11'(signed'({3'b000, c}));
        pc = 11'(signed'({2'b00, ab_sum})) - 11'(signed'({2'b00, c, 1'b0}));
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;

        case (e_item_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                begin
                    pred = a;
                end
                else if (pb <= pc)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
        result = e_item_reg.raw_byte + pred;

        e_valid_next = pop ? 1'b1 : (e_adv ? 1'b0 : e_valid_reg);
        out_valid_next = e_adv ? 1'b1 : (pixels.ready ? 1'b0 : out_valid_reg);
    end

    // Line buffer: one read on pop, one write as a word retires.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            above_rd_reg <= line_mem[head.col];
        end
        if (e_adv)
        begin
            line_mem[e_item_reg.col] <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_item_reg   <= head;
            // same column written this cycle (one-byte rows): forward it
            byp_hit_reg  <= e_adv && (e_item_reg.col == head.col);
            byp_data_reg <= result;
        end
        if (e_adv)
        begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--)
            begin
                left_hist_reg[i] <= left_hist_reg[i-1];
                up_hist_reg[i]   <= up_hist_reg[i-1];
            end
            left_hist_reg[0] <= result;
            up_hist_reg[0]   <= b;
            out_byte_reg     <= result;
            out_last_reg     <= e_item_reg.last;
            out_bad_reg      <= e_item_reg.filt == FILT_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg   <= e_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/png_scanline_unfilter.sv @@
// PNG scanline unfilter: one byte word per cycle in while the queue has room, one
// reconstructed byte out per data byte. A data byte passes through the queue, the execute
// register and the output register. Throughput: one byte per cycle while the sink is ready;
// the line buffer has a single read and a single write port. Filter bytes give no result.
// Reset (rst_n, async low) clears control state; the line buffer is not cleared, the
// first row of an image reads its above bytes as zero.
`default_nettype none

module png_scanline_unfilter import psu_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    psu_stream_if.sink  stream,
    psu_pixel_if.source pixels,
    psu_cfg_if.sink     cfg
);

    logic [BPP_W-1:0] bpp_reg;
    logic [ROW_W-1:0] row_reg;
    cfg_view_t        cfg_view;

    logic   push;
    qitem_t push_item;
    logic   pop;
    qitem_t head;
    logic   head_valid;
    logic   full;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (bpp_reg == '0)
        begin
            cfg_view.bpp_idx = '0;
        end
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
        begin
            cfg_view.bpp_idx = BPP_IDX_W'(MAX_PIXEL_BYTES - 1);
        end
        else
        begin
            cfg_view.bpp_idx = BPP_IDX_W'(bpp_reg - BPP_W'(1));
        end

        if (row_reg == '0)
        begin
            cfg_view.row_len = ROW_W'(1);
        end
        else if (row_reg > ROW_W'(MAX_ROW_BYTES))
        begin
            cfg_view.row_len = ROW_W'(MAX_ROW_BYTES);
        end
        else
        begin
            cfg_view.row_len = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_RESET;
            row_reg <= ROW_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_PIXEL_STRIDE: bpp_reg <= cfg.data[BPP_W-1:0];
                REG_ROW_BYTES:    row_reg <= cfg.data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    psu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cfg_view  (cfg_view),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bpp_idx    (cfg_view.bpp_idx),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .pixels     (pixels)
    );

endmodule

`default_nettype wire

@@ design/psu_checker.sv @@
// Port-level checker for the PNG scanline unfilter, bound to the top level.
// Depends on psu_pkg and png_scanline_unfilter_macros.svh.
`default_nettype none
`include "png_scanline_unfilter_macros.svh"

module psu_checker import psu_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_in_row,
    input wire logic       bad_filter
);

    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 4;
    localparam int IDLE_W       = $clog2(DRAIN_CYCLES + 1);

    logic [IDLE_W-1:0] idle_cnt_reg, idle_cnt_next;

    // consecutive cycles with no word in and the sink taking results
    always_comb
    begin
        if (in_valid && in_ready || !out_ready)
        begin
            idle_cnt_next = '0;
        end
        else if (idle_cnt_reg == IDLE_W'(DRAIN_CYCLES))
        begin
            idle_cnt_next = idle_cnt_reg;
        end
        else
        begin
            idle_cnt_next = idle_cnt_reg + IDLE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cnt_reg <= '0;
        end
        else
        begin
            idle_cnt_reg <= idle_cnt_next;
        end
    end

    `PSU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PSU_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_byte) && $stable(last_in_row) && $stable(bad_filter))
    `PSU_ASSERT_IMP(a_reset_idle, clk, rst_n, $rose(rst_n), !out_valid)
    `PSU_ASSERT_IMP(a_drains, clk, rst_n, idle_cnt_reg == IDLE_W'(DRAIN_CYCLES), !out_valid)

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (stream.valid),
    .in_ready    (stream.ready),
    .out_valid   (pixels.valid),
    .out_ready   (pixels.ready),
    .out_byte    (pixels.out_byte),
    .last_in_row (pixels.last_in_row),
    .bad_filter  (pixels.bad_filter)
);

`default_nettype wire
